@@ rtl/cfir_pkg.sv @@
// cfir_pkg: shared types and constants of the centered fir filter
// holds the sizes, the command codes and the token that travels the cell chain
// no dependencies

package cfir_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_W      = 16;
    localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W   = $clog2(MAX_TAPS + 1);
    localparam int PROD_W      = COEF_W + SAMPLE_BITS;
    localparam int ACC_W       = 38;
    localparam int POS_W       = 32;

    typedef enum logic
    {
        CMD_COEF_WR = 1'b0,
        CMD_SAMPLE  = 1'b1
    } cmd_t;

    // partial sum moving from one cell to the next
    typedef struct packed
    {
        logic                    valid;
        logic signed [ACC_W-1:0] sum;
    } token_t;

endpackage

@@ rtl/centered_fir_filter_unit.sv @@
// centered_fir_filter_unit: top level of the centered fir filter
// a row of cfir_cell taps with the stream bookkeeping and the output register
// depends on cfir_pkg and cfir_cell

// Coefficient writes and samples that do not complete a window are taken one
// per cycle while no partial sum is in flight. A sample that yields a result
// holds off further input from its beat until its partial sum has landed in
// the output register: the sum walks the full row of MAX_TAPS cells, one cell
// per cycle unless the row is held, after the products of the new window have
// been registered. The output register lets the next item enter while a result
// waits downstream; a result that reaches the end of the row while the output
// is still full and stalled holds the row. tap_count is written through the
// cfg port (always ready) and takes values 1 to MAX_TAPS; zero acts as one and
// larger values act as MAX_TAPS. The output position is the stream index of
// the newest sample minus (taps - 1) / 2, modulo 2^32.

module centered_fir_filter_unit
    import cfir_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [TAP_IDX_W-1:0]          coef_index,
    input  logic signed [COEF_W-1:0]      coef_value,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          first_of_stream,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [ACC_W-1:0]       filtered,
    output logic [POS_W-1:0]              output_position,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [TAP_CNT_W-1:0]          tap_count
);

    logic [TAP_CNT_W-1:0]    tap_count_reg;
    logic [TAP_CNT_W-1:0]    taps;
    logic [TAP_CNT_W-1:0]    half_taps;
    logic [TAP_CNT_W-1:0]    fill_reg;
    logic [TAP_CNT_W-1:0]    fill_base;
    logic [TAP_CNT_W-1:0]    fill_next;
    logic [POS_W-1:0]        cnt_reg;
    logic [POS_W-1:0]        idx;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic                    busy_reg;
    logic                    start_reg;
    logic                    start2_reg;
    logic                    out_valid_reg;
    logic signed [ACC_W-1:0] filtered_reg;
    logic [POS_W-1:0]        position_reg;

    logic accept;
    logic is_sample;
    logic sample_beat;
    logic fire;
    logic adv;
    logic out_load;

    token_t                        tok [0:MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] xs  [0:MAX_TAPS];
    logic [MAX_TAPS-1:0]           tap_en;
    logic [MAX_TAPS-1:0]           tok_valids;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy_reg;
    assign accept    = in_valid && !in_stall;
    assign is_sample = (cmd == CMD_SAMPLE);
    assign sample_beat = accept && is_sample;

    // taps in use: zero acts as one, saturate at the row length
    always_comb
    begin
        taps = tap_count_reg;
        if (tap_count_reg == '0)
        begin
            taps = TAP_CNT_W'(1);
        end
        else if (tap_count_reg > TAP_CNT_W'(MAX_TAPS))
        begin
            taps = TAP_CNT_W'(MAX_TAPS);
        end
    end

    assign half_taps = (taps - TAP_CNT_W'(1)) >> 1;

    always_comb
    begin
        fill_base = first_of_stream ? '0 : fill_reg;
        fill_next = (fill_base < TAP_CNT_W'(MAX_TAPS)) ? fill_base + TAP_CNT_W'(1) : fill_base;
        idx       = first_of_stream ? '0 : cnt_reg;
        pos_next  = idx - POS_W'(half_taps);
        fire      = (fill_next >= taps);
    end

    // hold the row when a finished sum cannot leave
    assign adv      = !(tok[MAX_TAPS].valid && out_valid_reg && out_stall);
    assign out_load = tok[MAX_TAPS].valid && adv;

    assign tok[0].valid = start2_reg;
    assign tok[0].sum   = '0;
    assign xs[0]        = sample;

    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++)
        begin : g_cell
            assign tap_en[k]     = (TAP_CNT_W'(k) < taps);
            assign tok_valids[k] = tok[k+1].valid;

            cfir_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .adv        (adv),
                .coef_we    (accept && !is_sample && (coef_index == TAP_IDX_W'(k))),
                .coef_wdata (coef_value),
                .shift_en   (sample_beat),
                .x_in       (xs[k]),
                .x_out      (xs[k+1]),
                .tap_en     (tap_en[k]),
                .tok_in     (tok[k]),
                .tok_out    (tok[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_CNT_W'(1);
            fill_reg      <= '0;
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            start2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tap_count_reg <= tap_count;
            end
            if (sample_beat)
            begin
                fill_reg <= fill_next;
                cnt_reg  <= idx + POS_W'(1);
            end
            start_reg  <= sample_beat && fire;
            start2_reg <= start_reg;
            if (sample_beat && fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_beat && fire)
        begin
            pos_reg <= pos_next;
        end
        if (out_load)
        begin
            filtered_reg <= tok[MAX_TAPS].sum;
            position_reg <= pos_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered        = filtered_reg;
    assign output_position = position_reg;

    // only one partial sum is ever in the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valids) <= 1)
        else $error("more than one partial sum in the cell row");

    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start_reg || start2_reg || (tok_valids != '0)) |-> busy_reg)
        else $error("partial sum in flight while input is open");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && !busy_reg))
        else $error("finished sum did not reach the output register");

    a_no_start_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> !$past(busy_reg))
        else $error("new window started while a sum was in flight");

endmodule

@@ rtl/cfir_cell.sv @@
// cfir_cell: one tap of the filter chain
// holds a coefficient, a delay line sample and its product, and adds the product
// to the partial sum passing by when the tap is in use; depends on cfir_pkg

module cfir_cell
    import cfir_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          coef_we,
    input  logic signed [COEF_W-1:0]      coef_wdata,
    input  logic                          shift_en,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    output logic signed [SAMPLE_BITS-1:0] x_out,
    input  logic                          tap_en,
    input  token_t                        tok_in,
    output token_t                        tok_out
);

    logic signed [COEF_W-1:0]      coef_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [ACC_W-1:0]       sum_reg;
    logic signed [ACC_W-1:0]       sum_next;
    logic                          tok_valid_reg;

    assign prod_next = coef_reg * x_reg;

    // taps beyond the count in use add nothing
    assign sum_next = tap_en ? (tok_in.sum + ACC_W'(prod_reg)) : tok_in.sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_reg <= coef_wdata;
        end
        if (shift_en)
        begin
            x_reg <= x_in;
        end
        prod_reg <= prod_next;
        if (adv && tok_in.valid)
        begin
            sum_reg <= sum_next;
        end
    end

    assign x_out         = x_reg;
    assign tok_out.valid = tok_valid_reg;
    assign tok_out.sum   = sum_reg;

endmodule

@@ verif/centered_fir_filter_unit_test.sv @@
// centered_fir_filter_unit_test: self-checking testbench of the centered fir filter
// predicts every filtered beat and its centred position, with random idling and stalls
// depends on cfir_pkg and centered_fir_filter_unit

module centered_fir_filter_unit_test;

    import cfir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = MAX_TAPS + 16;

    typedef struct packed
    {
        logic signed [ACC_W-1:0] filtered;
        logic [POS_W-1:0]        position;
    } filter_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          cmd;
    logic [TAP_IDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]      coef_value;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first_of_stream;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [ACC_W-1:0]       filtered;
    logic [POS_W-1:0]              output_position;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [TAP_CNT_W-1:0]          tap_count;

    // filter state as the testbench sees it
    logic signed [COEF_W-1:0]      coef_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
    logic [TAP_IDX_W-1:0]          hist_wr;
    logic [POS_W-1:0]              stream_index;
    int unsigned                   fill_level;
    logic [TAP_CNT_W-1:0]          taps_setting;

    filter_result_t pending_outputs [$];
    int             error_count;
    int             cycle_count;
    int             gap_pct;
    int             stall_pct;
    int             hold_req;

    centered_fir_filter_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .coef_index      (coef_index),
        .coef_value      (coef_value),
        .sample          (sample),
        .first_of_stream (first_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered        (filtered),
        .output_position (output_position),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .tap_count       (tap_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned taps_in_effect(logic [TAP_CNT_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_TAPS)
            return MAX_TAPS;
        return setting;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic predict_filter_output(cmd_t op, logic [TAP_IDX_W-1:0] idx,
                                         logic signed [COEF_W-1:0] cv,
                                         logic signed [SAMPLE_BITS-1:0] smp,
                                         logic new_stream);
        int unsigned          taps;
        logic [TAP_IDX_W-1:0] rd;
        logic [POS_W-1:0]     newest;
        longint               acc;
        filter_result_t       res;
        if (op == CMD_COEF_WR)
        begin
            coef_mem[idx] = cv;
            return;
        end
        if (new_stream)
        begin
            stream_index = '0;
            fill_level = 0;
        end
        history[hist_wr] = smp;
        newest = stream_index;
        stream_index = stream_index + 1'b1;
        if (fill_level < MAX_TAPS)
            fill_level++;
        rd = hist_wr;
        hist_wr = hist_wr + 1'b1;
        taps = taps_in_effect(taps_setting);
        if (fill_level < taps)
            return;
        acc = 0;
        // walk back from the newest sample, the index wraps with the delay line
        for (int k = 0; k < taps; k++)
        begin
            acc += longint'(coef_mem[k]) * longint'(history[rd]);
            rd = rd - 1'b1;
        end
        res.filtered = acc[ACC_W-1:0];
        res.position = newest - POS_W'((taps - 1) / 2);
        pending_outputs.push_back(res);
    endtask

    task automatic pause_input();
        int n;
        n = 0;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 3);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_item(cmd_t op, logic [TAP_IDX_W-1:0] idx,
                             logic signed [COEF_W-1:0] cv,
                             logic signed [SAMPLE_BITS-1:0] smp, logic new_stream);
        @(negedge clk);
        in_valid        <= 1'b1;
        cmd             <= op;
        coef_index      <= idx;
        coef_value      <= cv;
        sample          <= smp;
        first_of_stream <= new_stream;
        do
            @(posedge clk);
        while (in_stall);
        predict_filter_output(op, idx, cv, smp, new_stream);
        pause_input();
    endtask

    // fields that the command does not use carry random bits
    task automatic send_coef(int unsigned idx, logic [15:0] cv);
        send_item(CMD_COEF_WR, TAP_IDX_W'(idx), cv, 16'($urandom), 1'($urandom));
    endtask

    task automatic send_sample(logic [15:0] smp, logic new_stream);
        send_item(CMD_SAMPLE, TAP_IDX_W'($urandom), 16'($urandom), smp, new_stream);
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        // coefficient writes and unfilled samples leave nothing to wait for
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tap_count(int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        tap_count <= TAP_CNT_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        taps_setting = TAP_CNT_W'(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver side: random stalls, plus long hold-offs on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                stall_left = hold_req;
                hold_req = 0;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                out_stall <= 1'b1;
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        filter_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $error("unexpected beat: filtered %0d, output_position %0d",
                           filtered, output_position);
                    error_count++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (filtered !== want.filtered)
                    begin
                        $error("filtered: expected %0d, actual %0d", want.filtered, filtered);
                        error_count++;
                    end
                    if (output_position !== want.position)
                    begin
                        $error("output_position: expected %0d, actual %0d",
                               want.position, output_position);
                        error_count++;
                    end
                end
            end
        end
    end

    // every tap gets written before any window can read it
    task automatic test_coefficient_load();
        send_coef(0, 16'h8000);
        for (int k = 1; k < MAX_TAPS - 1; k++)
            send_coef(k, pick_value());
        send_coef(MAX_TAPS - 1, 16'h7fff);
    endtask

    task automatic test_single_tap();
        drain_outputs();
        write_tap_count(1);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hffff, 1'b0);
    endtask

    // largest magnitudes, window fill and a restart in the middle of a stream
    task automatic test_window_fill_and_restart();
        drain_outputs();
        write_tap_count(3);
        for (int k = 0; k < 3; k++)
            send_coef(k, 16'h8000);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h7fff, 1'b0);
        send_coef(1, 16'h7fff);
        send_sample(16'h8000, 1'b0);
    endtask

    task automatic test_tap_change_in_stream();
        drain_outputs();
        write_tap_count(4);
        send_sample(pick_value(), 1'b1);
        repeat (5) send_sample(pick_value(), 1'b0);
        drain_outputs();
        write_tap_count(8);
        repeat (3) send_sample(pick_value(), 1'b0);
        drain_outputs();
        write_tap_count(2);
        repeat (2) send_sample(pick_value(), 1'b0);
    endtask

    task automatic test_tap_count_zero();
        drain_outputs();
        write_tap_count(0);
        send_sample(pick_value(), 1'b1);
        send_sample(pick_value(), 1'b0);
    endtask

    // hold the output long enough that the row and the input back up
    task automatic test_backpressure();
        int saved_gap;
        int saved_stall;
        saved_gap = gap_pct;
        saved_stall = stall_pct;
        drain_outputs();
        write_tap_count(2);
        gap_pct = 0;
        stall_pct = 0;
        hold_req = 300;
        send_sample(pick_value(), 1'b1);
        repeat (25) send_sample(pick_value(), 1'b0);
        drain_outputs();
        repeat (8) send_sample(pick_value(), 1'b0);
        gap_pct = saved_gap;
        stall_pct = saved_stall;
    endtask

    task automatic run_stream_phase(int unsigned setting, int n_items);
        int unsigned taps;
        int          left;
        drain_outputs();
        write_tap_count(setting);
        taps = taps_in_effect(TAP_CNT_W'(setting));
        left = 0;
        for (int sent = 0; sent < n_items; sent++)
        begin
            if ($urandom_range(11) == 0)
                send_coef($urandom_range(MAX_TAPS - 1), pick_value());
            else
            begin
                if (left <= 0)
                begin
                    left = taps + $urandom_range(0, 30);
                    send_sample(pick_value(), 1'b1);
                end
                else
                    send_sample(pick_value(), $urandom_range(39) == 0);
                left--;
            end
        end
    endtask

    task automatic test_random_streams();
        int unsigned settings [10];
        settings = '{64, 127, 1, 2, 0, 37, 8, 64, 16, 5};
        settings[9] = $urandom_range(1, MAX_TAPS);
        for (int p = 0; p < 10; p++)
        begin
            // some phases run with no idling at all
            if (p % 4 == 2)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = $urandom_range(10, 40);
                stall_pct = $urandom_range(10, 40);
            end
            run_stream_phase(settings[p], 102);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        cmd             = CMD_COEF_WR;
        coef_index      = '0;
        coef_value      = '0;
        sample          = '0;
        first_of_stream = 1'b0;
        out_stall       = 1'b0;
        cfg_valid       = 1'b0;
        tap_count       = '0;
        hist_wr         = '0;
        stream_index    = '0;
        fill_level      = 0;
        taps_setting    = 1;
        error_count     = 0;
        gap_pct         = 20;
        stall_pct       = 20;
        hold_req        = 0;
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            coef_mem[k] = '0;
            history[k] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_coefficient_load();
        test_single_tap();
        test_window_fill_and_restart();
        test_tap_change_in_stream();
        test_tap_count_zero();
        test_backpressure();
        test_random_streams();
        drain_outputs();

        if (error_count == 0 && pending_outputs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
